FILE: rtl/core/ffa_pkg.sv
// Shared types and codes for the first-fit free-list allocator.
// No dependencies.
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 9;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] region_addr;
        logic [ADDR_W-1:0] region_size;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        logic [1:0]        status;
        logic [ADDR_W-1:0] free_total;
        logic [CNT_W-1:0]  entry_count;
        logic [CNT_W-1:0]  peak_entries;
        logic [ADDR_W-1:0] lost_count;
        logic [ADDR_W-1:0] lost_bytes;
    } rsp_t;

endpackage

FILE: rtl/core/first_fit_free_list_allocator_top.sv
// Top level of the first-fit free-list allocator: ring of ffa_cell slots plus sequencer.
// Depends on ffa_pkg and ffa_cell.
`timescale 1ns / 1ps
//
// channel | ports                    | payload
// --------+--------------------------+--------
// request | s_valid, s_ready, s_data | req_t
// result  | m_valid, m_ready, m_data | rsp_t
//
// Each transaction runs in order: an accept step, one full ring rotation to
// search, a decision step, one full rotation to apply the edit, and a post step.
// Reset is synchronous; the table contents are undefined until written.
// A pending result does not stop the next request from being accepted; the
// post step waits while the previous result is still stalled.

module first_fit_free_list_allocator_top import ffa_pkg::*; #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_EDIT   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t            state_reg;
    logic [IW-1:0]     t_reg;
    req_t              req_reg;
    logic [CW-1:0]     count_reg, peak_reg;
    logic [ADDR_W-1:0] free_reg, lost_cnt_reg, lost_bytes_reg;
    logic              found_reg, nxtv_reg;
    logic [CW-1:0]     sel_idx_reg;
    entry_t            sel_reg, prev_reg;
    logic              mod_en_reg, drop_en_reg, ins_en_reg;
    logic [CW-1:0]     mod_idx_reg, drop_idx_reg, ins_idx_reg;
    entry_t            mod_val_reg, ins_val_reg, hold_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [1:0]        res_status_reg;
    logic              m_valid_reg;
    rsp_t              m_data_reg;

    entry_t q [TABLE_ENTRIES];
    entry_t ring_in, e, la;
    logic   ring_en;
    logic [CW-1:0] tc;
    logic   v, hit, last;
    logic   prev_adj, next_adj;
    logic   out_free;

    assign ring_en = (state_reg == S_SCAN) || (state_reg == S_EDIT);
    assign e       = q[0];
    assign la      = q[1];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            if (gi == TABLE_ENTRIES - 1) begin : g_tail
                ffa_cell u_cell (.aclk(aclk), .shift_en(ring_en), .d(ring_in), .q(q[gi]));
            end else begin : g_body
                ffa_cell u_cell (.aclk(aclk), .shift_en(ring_en), .d(q[gi+1]), .q(q[gi]));
            end
        end
    endgenerate

    always_comb begin
        tc   = CW'(t_reg);
        last = (t_reg == IW'(TABLE_ENTRIES - 1));
        v    = tc < count_reg;
        if (req_reg.opcode == OP_ALLOC) begin
            hit = v && (e.size >= req_reg.region_size);
        end else begin
            hit = !v || (e.addr > req_reg.region_addr);
        end
        prev_adj = (sel_idx_reg != '0) &&
                   ((prev_reg.addr + prev_reg.size) == req_reg.region_addr);
        next_adj = nxtv_reg &&
                   ((req_reg.region_addr + req_reg.region_size) == sel_reg.addr);
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        ring_in = e;
        if (state_reg == S_EDIT) begin
            if (ins_en_reg && tc == ins_idx_reg) begin
                ring_in = ins_val_reg;
            end else if (ins_en_reg && tc > ins_idx_reg) begin
                ring_in = hold_reg;
            end else if (drop_en_reg && tc >= drop_idx_reg) begin
                ring_in = la;
            end else if (mod_en_reg && tc == mod_idx_reg) begin
                ring_in = mod_val_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            t_reg          <= '0;
            count_reg      <= '0;
            peak_reg       <= '0;
            free_reg       <= '0;
            lost_cnt_reg   <= '0;
            lost_bytes_reg <= '0;
            found_reg      <= 1'b0;
            nxtv_reg       <= 1'b0;
            mod_en_reg     <= 1'b0;
            drop_en_reg    <= 1'b0;
            ins_en_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg   <= S_SCAN;
                        t_reg       <= '0;
                        found_reg   <= 1'b0;
                        nxtv_reg    <= 1'b0;
                        mod_en_reg  <= 1'b0;
                        drop_en_reg <= 1'b0;
                        ins_en_reg  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (!found_reg && hit) begin
                        found_reg <= 1'b1;
                        nxtv_reg  <= v;
                    end
                    if (last) begin
                        t_reg     <= '0;
                        state_reg <= S_DECIDE;
                    end else begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                S_DECIDE: begin
                    state_reg <= S_EDIT;
                    if (req_reg.opcode == OP_ALLOC) begin
                        if (found_reg) begin
                            free_reg <= free_reg - req_reg.region_size;
                            if (sel_reg.size == req_reg.region_size) begin
                                drop_en_reg <= 1'b1;
                                count_reg   <= count_reg - 1'b1;
                            end else begin
                                mod_en_reg <= 1'b1;
                            end
                        end
                    end else if (prev_adj) begin
                        free_reg   <= free_reg + req_reg.region_size;
                        mod_en_reg <= 1'b1;
                        if (next_adj) begin
                            drop_en_reg <= 1'b1;
                            count_reg   <= count_reg - 1'b1;
                        end
                    end else if (next_adj) begin
                        free_reg   <= free_reg + req_reg.region_size;
                        mod_en_reg <= 1'b1;
                    end else if (count_reg < CW'(TABLE_ENTRIES)) begin
                        free_reg   <= free_reg + req_reg.region_size;
                        ins_en_reg <= 1'b1;
                        count_reg  <= count_reg + 1'b1;
                        if (count_reg + 1'b1 > peak_reg) begin
                            peak_reg <= count_reg + 1'b1;
                        end
                    end else begin
                        lost_cnt_reg   <= lost_cnt_reg + 1'b1;
                        lost_bytes_reg <= lost_bytes_reg + req_reg.region_size;
                    end
                end
                S_EDIT: begin
                    if (last) begin
                        t_reg     <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            req_reg     <= s_data;
            sel_idx_reg <= count_reg;
        end
        if (state_reg == S_SCAN) begin
            if (!found_reg && hit) begin
                sel_reg     <= e;
                sel_idx_reg <= tc;
            end else if (!found_reg) begin
                prev_reg <= e;
            end
        end
        if (state_reg == S_EDIT) begin
            hold_reg <= e;
        end
        if (state_reg == S_DECIDE) begin
            if (req_reg.opcode == OP_ALLOC) begin
                drop_idx_reg <= sel_idx_reg;
                mod_idx_reg  <= sel_idx_reg;
                mod_val_reg  <= '{addr: sel_reg.addr + req_reg.region_size,
                                  size: sel_reg.size - req_reg.region_size};
                if (found_reg) begin
                    res_addr_reg   <= sel_reg.addr;
                    res_status_reg <= STATUS_OK;
                end else begin
                    res_addr_reg   <= '0;
                    res_status_reg <= STATUS_NOFIT;
                end
            end else if (prev_adj) begin
                res_addr_reg   <= '0;
                res_status_reg <= STATUS_OK;
                mod_idx_reg    <= sel_idx_reg - 1'b1;
                drop_idx_reg   <= sel_idx_reg;
                mod_val_reg    <= '{addr: prev_reg.addr,
                                    size: prev_reg.size + req_reg.region_size +
                                          (next_adj ? sel_reg.size : '0)};
            end else if (next_adj) begin
                res_addr_reg   <= '0;
                res_status_reg <= STATUS_OK;
                mod_idx_reg    <= sel_idx_reg;
                mod_val_reg    <= '{addr: req_reg.region_addr,
                                    size: sel_reg.size + req_reg.region_size};
            end else begin
                res_addr_reg <= '0;
                ins_idx_reg  <= sel_idx_reg;
                ins_val_reg  <= '{addr: req_reg.region_addr, size: req_reg.region_size};
                if (count_reg >= CW'(TABLE_ENTRIES)) begin
                    res_status_reg <= STATUS_FULL;
                end else begin
                    res_status_reg <= STATUS_OK;
                end
            end
        end
        if (state_reg == S_DONE && out_free) begin
            m_data_reg.alloc_addr   <= res_addr_reg;
            m_data_reg.status       <= res_status_reg;
            m_data_reg.free_total   <= free_reg;
            m_data_reg.entry_count  <= CNT_W'(count_reg);
            m_data_reg.peak_entries <= CNT_W'(peak_reg);
            m_data_reg.lost_count   <= lost_cnt_reg;
            m_data_reg.lost_bytes   <= lost_bytes_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/ffa_cell.sv
// One slot of the free-region ring: holds an entry and passes it on when shifting.
// Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_cell import ffa_pkg::*; (
    input  logic   aclk,
    input  logic   shift_en,
    input  entry_t d,
    output entry_t q
);

    entry_t slot_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            slot_reg <= d;
        end
    end

    assign q = slot_reg;

endmodule

FILE: rtl/core/ffa_checker.sv
// Port-level checks for the allocator top, with the bind that attaches them.
// Depends on ffa_pkg and first_fit_free_list_allocator_top.
`timescale 1ns / 1ps

module ffa_checker import ffa_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_fail_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |-> m_data.alloc_addr == '0)
        else $error("failed transaction carries an address");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == STATUS_OK || m_data.status == STATUS_NOFIT ||
                    m_data.status == STATUS_FULL)
        else $error("bad status code");

    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= m_data.peak_entries)
        else $error("entry count above peak");

endmodule

bind first_fit_free_list_allocator_top ffa_checker u_ffa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/tb_first_fit_free_list_allocator_top.sv
// Self-checking testbench for first_fit_free_list_allocator_top: random and directed
// alloc/free traffic, results checked against an in-bench free-table predictor.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 1ps

import ffa_pkg::*;

class alloc_scoreboard;
    localparam int DEPTH = 256;
    entry_t            regions [DEPTH];
    int unsigned       used;
    int unsigned       peak;
    logic [ADDR_W-1:0] free_bytes;
    logic [ADDR_W-1:0] lost_n;
    logic [ADDR_W-1:0] lost_b;
    rsp_t              expected_q [$];
    int unsigned       errors;

    function new();
        used = 0;
        peak = 0;
        free_bytes = '0;
        lost_n = '0;
        lost_b = '0;
        errors = 0;
    endfunction

    function void remove_at(int unsigned k);
        used--;
        for (int unsigned j = k; j < used; j++) regions[j] = regions[j + 1];
    endfunction

    function void open_at(int unsigned k);
        for (int unsigned j = used; j > k; j--) regions[j] = regions[j - 1];
        used++;
    endfunction

    function rsp_t note_request(req_t r);
        rsp_t              p;
        int unsigned       k;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] s;
        bit                done;
        p = '0;
        a = r.region_addr;
        s = r.region_size;
        done = 0;
        if (r.opcode == OP_ALLOC) begin
            p.status = STATUS_NOFIT;
            for (k = 0; k < used && !done; k++) begin
                if (regions[k].size >= s) begin
                    p.alloc_addr = regions[k].addr;
                    p.status = STATUS_OK;
                    regions[k].addr += s;
                    regions[k].size -= s;
                    free_bytes -= s;
                    if (regions[k].size == 0) remove_at(k);
                    done = 1;
                end
            end
        end else begin
            p.status = STATUS_OK;
            k = 0;
            while (k < used && regions[k].addr <= a) k++;
            if (k > 0 && ADDR_W'(regions[k-1].addr + regions[k-1].size) == a) begin
                regions[k-1].size += s;
                if (k < used && ADDR_W'(a + s) == regions[k].addr) begin
                    regions[k-1].size += regions[k].size;
                    remove_at(k);
                end
                free_bytes += s;
            end else if (k < used && ADDR_W'(a + s) == regions[k].addr) begin
                regions[k].addr = a;
                regions[k].size += s;
                free_bytes += s;
            end else if (used < DEPTH) begin
                open_at(k);
                if (peak < used) peak = used;
                regions[k].addr = a;
                regions[k].size = s;
                free_bytes += s;
            end else begin
                lost_n++;
                lost_b += s;
                p.status = STATUS_FULL;
            end
        end
        p.free_total   = free_bytes;
        p.entry_count  = CNT_W'(used);
        p.peak_entries = CNT_W'(peak);
        p.lost_count   = lost_n;
        p.lost_bytes   = lost_b;
        expected_q.push_back(p);
        return p;
    endfunction

    function void check_result(rsp_t got);
        rsp_t e;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction: %p", got);
            return;
        end
        e = expected_q.pop_front();
        if (got.alloc_addr !== e.alloc_addr || got.status !== e.status ||
            got.free_total !== e.free_total || got.entry_count !== e.entry_count ||
            got.peak_entries !== e.peak_entries || got.lost_count !== e.lost_count ||
            got.lost_bytes !== e.lost_bytes) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected %p, got %p", e, got);
        end
    endfunction
endclass

module tb_first_fit_free_list_allocator_top;

    localparam longint CYCLE_LIMIT = 64'd6_000_000;
    localparam int     DRAIN_WAIT  = 600;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    alloc_scoreboard  sb = new();
    entry_t           live_q [$];
    longint           cycles = 0;
    int unsigned      stall_left = 0;

    first_fit_free_list_allocator_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[first_fit_free_list_allocator_top] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left <= pick_gap();
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send(input req_t r);
        rsp_t p;
        int unsigned g;
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        p = sb.note_request(r);
        if (r.opcode == OP_ALLOC && p.status == STATUS_OK && r.region_size != 0)
            live_q.push_back('{addr: p.alloc_addr, size: r.region_size});
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_op(input logic op, input logic [31:0] a, input logic [31:0] s);
        req_t r;
        r.opcode = op;
        r.region_addr = a;
        r.region_size = s;
        send(r);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic mixed_traffic(input int unsigned n);
        int unsigned r;
        int unsigned idx;
        entry_t e;
        for (int unsigned i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                if ($urandom_range(0, 9) == 0) send_op(OP_ALLOC, $urandom, $urandom);
                else send_op(OP_ALLOC, $urandom, $urandom_range(1, 256));
            end else if (r < 65 && live_q.size() > 0) begin
                idx = $urandom_range(0, live_q.size() - 1);
                e = live_q[idx];
                live_q.delete(idx);
                send_op(OP_FREE, e.addr, e.size);
            end else if (r < 88) begin
                send_op(OP_FREE, {4'($urandom_range(0, 15)), 4'h0,
                                  12'($urandom_range(0, 4095)), 12'h0},
                        $urandom_range(1, 4096));
            end else begin
                send_op(logic'($urandom_range(0, 1)), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, zero sizes, merges, wrap, extremes
        send_op(OP_ALLOC, 32'hFFFF_FFFF, 32'd5);
        send_op(OP_ALLOC, 32'h0, 32'd0);
        send_op(OP_FREE, 32'h500, 32'd0);
        send_op(OP_ALLOC, 32'h0, 32'd0);
        send_op(OP_FREE, 32'h1000, 32'h100);
        send_op(OP_FREE, 32'h1100, 32'h80);
        send_op(OP_FREE, 32'hF00, 32'h100);
        send_op(OP_FREE, 32'h1300, 32'h40);
        send_op(OP_FREE, 32'h1180, 32'h180);
        send_op(OP_ALLOC, 32'h0, 32'h10);
        send_op(OP_ALLOC, 32'h0, 32'h430);
        send_op(OP_FREE, 32'h1000, 32'h0);
        send_op(OP_ALLOC, 32'h0, 32'h0);
        send_op(OP_FREE, 32'hFFFF_FF80, 32'h80);
        send_op(OP_FREE, 32'hFFFF_FF00, 32'h80);
        send_op(OP_FREE, 32'h0, 32'h20);
        send_op(OP_ALLOC, 32'h0, 32'h1000);
        send_op(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_ALLOC, 32'h0, 32'h100);
        send_op(OP_FREE, 32'h2000, 32'h10);
        wait_idle();

        mixed_traffic(450);
        wait_idle();

        // fill the table past capacity so releases get dropped
        for (int unsigned i = 0; i < 300; i++)
            send_op(OP_FREE, 32'h8000_0000 + i * 32'h1000 + $urandom_range(0, 255),
                    $urandom_range(1, 64));
        for (int unsigned i = 0; i < 100; i++)
            send_op(OP_ALLOC, $urandom, $urandom_range(1, 96));

        mixed_traffic(280);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[first_fit_free_list_allocator_top] OK");
        else
            $display("[first_fit_free_list_allocator_top] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ffa_pkg.sv
rtl/core/ffa_cell.sv
rtl/core/first_fit_free_list_allocator_top.sv
rtl/core/ffa_checker.sv
tb/tb_first_fit_free_list_allocator_top.sv
